// File: rtl/mfw_pkg.sv
// ----------------------------------------------------------------------------
// mfw_pkg: shared constants and types for the median filter window unit
// Register map, field widths and the small helpers used across modules.
// ----------------------------------------------------------------------------
package mfw_pkg;

	localparam int MAX_RADIUS_DEF = 4;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int HEIGHT_LIMIT   = 4096;

	localparam int PIX_W   = 8;
	localparam int RAD_W   = 3;
	localparam int WID_W   = 11;
	localparam int HGT_W   = 13;
	localparam int ADDR_W  = 4;

	localparam logic [ADDR_W-1:0] REG_RADIUS = 4'h0;
	localparam logic [ADDR_W-1:0] REG_WIDTH  = 4'h4;
	localparam logic [ADDR_W-1:0] REG_HEIGHT = 4'h8;

	typedef logic [PIX_W-1:0] pix_t;

	// settings as used by the datapath, already clamped
	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [WID_W-1:0] width;
		logic [HGT_W-1:0] height;
	} cfg_t;

endpackage

// File: rtl/mfw_if.sv
// ----------------------------------------------------------------------------
// mfw_in_if / mfw_out_if: valid/ready channels of the filter
// Input carries req_type and pixel_in, output carries pixel_out, frame_last.
// ----------------------------------------------------------------------------
interface mfw_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [7:0] pixel_in;
	modport source (output valid, req_type, pixel_in, input ready);
	modport sink (input valid, req_type, pixel_in, output ready);
endinterface

interface mfw_out_if;
	logic valid;
	logic ready;
	logic [7:0] pixel_out;
	logic frame_last;
	modport source (output valid, pixel_out, frame_last, input ready);
	modport sink (input valid, pixel_out, frame_last, output ready);
endinterface

// File: rtl/mfw_cfg.sv
// ----------------------------------------------------------------------------
// mfw_cfg: APB register file
// Holds radius, width and height; raw values read back, clamped copy used.
// ----------------------------------------------------------------------------
module mfw_cfg #(
	parameter int MAX_RADIUS = mfw_pkg::MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = mfw_pkg::MAX_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mfw_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic wr_done,
	output mfw_pkg::cfg_t cfg
);
	logic [mfw_pkg::RAD_W-1:0] radius_q;
	logic [mfw_pkg::WID_W-1:0] width_q;
	logic [mfw_pkg::HGT_W-1:0] height_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= mfw_pkg::RAD_W'(1);
			width_q  <= mfw_pkg::WID_W'(640);
			height_q <= mfw_pkg::HGT_W'(480);
			wr_done  <= 1'b0;
		end else begin
			wr_done <= 1'b0;
			if (wr) begin
				case (paddr)
					mfw_pkg::REG_RADIUS: begin
						radius_q <= pwdata[mfw_pkg::RAD_W-1:0];
						wr_done <= 1'b1;
					end
					mfw_pkg::REG_WIDTH: begin
						width_q <= pwdata[mfw_pkg::WID_W-1:0];
						wr_done <= 1'b1;
					end
					mfw_pkg::REG_HEIGHT: begin
						height_q <= pwdata[mfw_pkg::HGT_W-1:0];
						wr_done <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr)
			mfw_pkg::REG_RADIUS: prdata = 32'(radius_q);
			mfw_pkg::REG_WIDTH:  prdata = 32'(width_q);
			mfw_pkg::REG_HEIGHT: prdata = 32'(height_q);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		cfg.radius = radius_q;
		if (radius_q == '0) cfg.radius = mfw_pkg::RAD_W'(1);
		else if (32'(radius_q) > MAX_RADIUS) cfg.radius = mfw_pkg::RAD_W'(MAX_RADIUS);
		cfg.width = width_q;
		if (width_q == '0) cfg.width = mfw_pkg::WID_W'(1);
		else if (32'(width_q) > MAX_WIDTH) cfg.width = mfw_pkg::WID_W'(MAX_WIDTH);
		cfg.height = height_q;
		if (height_q == '0) cfg.height = mfw_pkg::HGT_W'(1);
		else if (32'(height_q) > mfw_pkg::HEIGHT_LIMIT)
			cfg.height = mfw_pkg::HGT_W'(mfw_pkg::HEIGHT_LIMIT);
	end
endmodule

// File: rtl/mfw_median.sv
// ----------------------------------------------------------------------------
// mfw_median: pipelined median by rank counting
// Stage 1 compares every window pair, stage 2 sums ranks per element,
// stage 3 picks the element whose rank is the middle one.
// ----------------------------------------------------------------------------
module mfw_median #(
	parameter int MAX_RADIUS = mfw_pkg::MAX_RADIUS_DEF,
	localparam int SIDE = 2 * MAX_RADIUS - 1,
	localparam int N = SIDE * SIDE,
	localparam int CW = $clog2(N + 1)
) (
	input  logic clk,
	input  logic en,
	input  mfw_pkg::pix_t win [N],
	input  logic [N-1:0] act,
	input  logic [CW-1:0] mid,
	output mfw_pkg::pix_t med
);
	// less_s1[i][j]: element j sorts before element i (ties by index)
	logic [N-1:0] less_s1 [N];
	logic [N-1:0] act_s1;
	mfw_pkg::pix_t win_s1 [N];
	logic [CW-1:0] mid_s1, mid_s2;
	logic [CW-1:0] rank_s2 [N];
	logic [N-1:0] act_s2;
	mfw_pkg::pix_t win_s2 [N];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				for (int j = 0; j < N; j++)
					less_s1[i][j] <= (win[j] < win[i]) || (win[j] == win[i] && j < i);
				win_s1[i] <= win[i];
			end
			act_s1 <= act;
			mid_s1 <= mid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				rank_s2[i] <= CW'($countones(less_s1[i] & act_s1));
				win_s2[i] <= win_s1[i];
			end
			act_s2 <= act_s1;
			mid_s2 <= mid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++)
				if (act_s2[i] && rank_s2[i] == mid_s2) med <= win_s2[i];
		end
	end
endmodule

// File: rtl/mfw_window.sv
// ----------------------------------------------------------------------------
// mfw_window: line buffers and window registers
// Keeps SIDE-1 rows in memories; window shifts one column per accepted word.
// ----------------------------------------------------------------------------
module mfw_window #(
	parameter int MAX_RADIUS = mfw_pkg::MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = mfw_pkg::MAX_WIDTH_DEF,
	localparam int SIDE = 2 * MAX_RADIUS - 1,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic wr_en,
	input  logic [AW-1:0] col,
	input  mfw_pkg::pix_t pix,
	output mfw_pkg::pix_t win [SIDE*SIDE]
);
	// row 0 is newest; row r of window column comes from line memory r-1
	mfw_pkg::pix_t col_s1 [SIDE];
	mfw_pkg::pix_t pix_s1;
	logic [AW-1:0] addr_s1;
	logic vld_s1;
	logic wp_q;
	mfw_pkg::pix_t grid_q [SIDE][SIDE];

	generate
		if (SIDE > 1) begin : g_lines
			mfw_pkg::pix_t rd_s1 [SIDE-1];
			for (genvar r = 0; r < SIDE - 1; r++) begin : g_mem
				mfw_pkg::pix_t mem [MAX_WIDTH];
				if (r == 0) begin : g_head
					always_ff @(posedge clk) begin
						if (wr_en) begin
							mem[col] <= pix;
							rd_s1[r] <= mem[col];
						end
					end
				end else begin : g_tail
					// word read from the line above is written in the cycle after its read;
					// a read of that same column takes it from the register
					always_ff @(posedge clk) begin
						if (wp_q) mem[addr_s1] <= rd_s1[r-1];
						if (wr_en)
							rd_s1[r] <= (wp_q && col == addr_s1) ? rd_s1[r-1] : mem[col];
					end
				end
			end
			always_comb begin
				col_s1[0] = pix_s1;
				for (int r = 1; r < SIDE; r++) col_s1[r] = rd_s1[r-1];
			end
		end else begin : g_one
			always_comb col_s1[0] = pix_s1;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pix_s1 <= pix;
			addr_s1 <= col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			wp_q <= wr_en;
			if (en) vld_s1 <= wr_en;
		end
	end

	// window newest column at index 0; shifts only for a new word
	always_ff @(posedge clk) begin
		if (en && vld_s1) begin
			for (int r = 0; r < SIDE; r++) begin
				grid_q[r][0] <= col_s1[r];
				for (int c = 1; c < SIDE; c++) grid_q[r][c] <= grid_q[r][c-1];
			end
		end
	end

	always_comb begin
		for (int r = 0; r < SIDE; r++)
			for (int c = 0; c < SIDE; c++)
				win[r*SIDE+c] = grid_q[r][c];
	end
endmodule

// File: rtl/median_filter_window_unit.sv
// ----------------------------------------------------------------------------
// median_filter_window_unit: streaming 2D median filter, square window
// Use: program kernel_radius (0x0), image_width (0x4), image_height (0x8)
// over APB while idle; a write restarts the frame. Feed pixels in raster
// order on in_ch (req_type 0) and after each frame (k-1)*width+(k-1) drain
// pads (req_type 1). Filtered pixels leave on out_ch in raster order;
// frame_last marks the last one.
// Throughput: one word per cycle while out_ch does not stall. Each word
// passes five register stages (store read, window shift, compare, rank
// sum, select) before its result is offered.
// Reset clears counters and pipeline valids; no clearing pass is needed.
// When out_ch stalls the whole pipeline holds; in_ch ready follows
// out_ch ready or an empty output stage, so nothing is lost or repeated.
// Line store: 2*(R-1) cascaded line memories of W pixels, each read and
// written once per word.
// ----------------------------------------------------------------------------
module median_filter_window_unit #(
	parameter int MAX_RADIUS = mfw_pkg::MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = mfw_pkg::MAX_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [mfw_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	mfw_in_if.sink in_ch,
	mfw_out_if.source out_ch
);
	localparam int SIDE = 2 * MAX_RADIUS - 1;
	localparam int N = SIDE * SIDE;
	localparam int CW = $clog2(N + 1);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int DEPTH = 5;

	mfw_pkg::cfg_t cfg;
	logic wr_done;
	logic en, acc;
	mfw_pkg::pix_t win [N];
	mfw_pkg::pix_t med;
	logic [N-1:0] act;
	logic [CW-1:0] mid;

	logic [mfw_pkg::WID_W-1:0] in_col_q, out_col_q;
	logic [mfw_pkg::HGT_W-1:0] in_row_q, out_row_q;
	logic [mfw_pkg::WID_W+mfw_pkg::RAD_W-1:0] lag_cnt_q;
	logic [mfw_pkg::WID_W+mfw_pkg::RAD_W-1:0] lag;
	logic [mfw_pkg::RAD_W-1:0] k;
	logic [mfw_pkg::WID_W-1:0] w;
	logic [mfw_pkg::HGT_W-1:0] h;
	logic emit, last, interior, out_active_q;

	logic [DEPTH-1:0] vld_q;
	logic last_p [DEPTH];
	logic int_p [DEPTH];
	mfw_pkg::pix_t ctr_p [DEPTH];
	mfw_pkg::pix_t ctr_now;

	mfw_cfg #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .wr_done, .cfg
	);

	assign k = cfg.radius;
	assign w = cfg.width;
	assign h = cfg.height;
	assign lag = (mfw_pkg::WID_W+mfw_pkg::RAD_W)'((k - 1'b1) * w + (k - 1'b1));

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign acc = in_ch.valid && in_ch.ready;

	// window of the item centered (k-1) rows and columns behind input
	mfw_window #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_win (
		.clk, .arst_n, .en, .wr_en(acc),
		.col(in_col_q[AW-1:0]),
		.pix((in_ch.req_type || in_row_q >= h) ? '0 : in_ch.pixel_in),
		.win
	);

	// active square holds the newest 2k-1 rows and columns
	always_comb begin
		for (int r = 0; r < SIDE; r++)
			for (int c = 0; c < SIDE; c++)
				act[r*SIDE+c] = (r < 2*k-1) && (c < 2*k-1);
		mid = CW'(((2*k-1)*(2*k-1)) / 2);
	end

	mfw_median #(.MAX_RADIUS(MAX_RADIUS)) u_med (
		.clk, .en, .win, .act, .mid, .med
	);

	// center tap for pass-through pixels
	always_comb begin
		ctr_now = win[0];
		for (int i = 0; i < N; i++)
			if (i == (int'(k) - 1) * SIDE + int'(k) - 1) ctr_now = win[i];
	end

	assign emit = acc && (out_active_q || lag_cnt_q >= lag) && out_row_q < h;
	assign last = (out_row_q == h - 1'b1) && (out_col_q == w - 1'b1);
	assign interior = out_row_q >= 13'(k) && 14'(out_row_q) + 14'(k) < 14'(h)
		&& out_col_q >= 11'(k) && 12'(out_col_q) + 12'(k) < 12'(w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0; in_row_q <= '0;
			out_col_q <= '0; out_row_q <= '0;
			lag_cnt_q <= '0; out_active_q <= 1'b0;
		end else if (wr_done) begin
			in_col_q <= '0; in_row_q <= '0;
			out_col_q <= '0; out_row_q <= '0;
			lag_cnt_q <= '0; out_active_q <= 1'b0;
		end else if (acc) begin
			if (emit && last) begin
				in_col_q <= '0; in_row_q <= '0;
				out_col_q <= '0; out_row_q <= '0;
				lag_cnt_q <= '0; out_active_q <= 1'b0;
			end else begin
				if (in_col_q + 1'b1 >= w) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else in_col_q <= in_col_q + 1'b1;
				if (lag_cnt_q < lag) lag_cnt_q <= lag_cnt_q + 1'b1;
				if (emit) begin
					out_active_q <= 1'b1;
					if (out_col_q + 1'b1 >= w) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// sideband pipeline: valid, last, interior, center value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], emit};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_p[0] <= last;
			int_p[0] <= interior;
			ctr_p[0] <= '0;
			for (int i = 1; i < DEPTH; i++) begin
				last_p[i] <= last_p[i-1];
				int_p[i] <= int_p[i-1];
				ctr_p[i] <= (i == 2) ? ctr_now : ctr_p[i-1];
			end
		end
	end

	assign out_ch.valid = vld_q[DEPTH-1];
	assign out_ch.frame_last = last_p[DEPTH-1];
	assign out_ch.pixel_out = int_p[DEPTH-1] ? med : ctr_p[DEPTH-1];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pixel_out))
		else $error("output word changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		wr_done |=> in_col_q == '0 && out_row_q == '0)
		else $error("counters not cleared after register write");
endmodule
